@@ sv/eqr_pkg.sv @@
// ----------------------------------------------------------------------------
// eqr_pkg
// shared constants, command and status types of the ellipse quadrant rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package eqr_pkg;

    localparam int COORD_W   = 10;
    localparam int COLOR_W   = 4;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int OP_W      = 2 * (COORD_W + 1);
    localparam int PROD_W    = 2 * OP_W;
    localparam int DEC_W     = 4 * COORD_W + 8;
    localparam int S_TDATA_W = ((2 * COORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * COORD_W + COLOR_W + 7) / 8) * 8;

    localparam logic [COLOR_W-1:0] COLOR_RESET = COLOR_W'(15);

    typedef enum logic [0:0] {
        ACT_START = 1'b0,
        ACT_STEP  = 1'b1
    } action_t;

    typedef enum logic [3:0] {
        MUL_A_A,
        MUL_B_B,
        MUL_AA_B,
        MUL_BB_X1,
        MUL_AA_Y2M1,
        MUL_BB_X23,
        MUL_AA_Y,
        MUL_HX_HX,
        MUL_YM_YM,
        MUL_BB_T1,
        MUL_AA_T2,
        MUL_AA_BB
    } mul_sel_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD_AA,
        OP_LOAD_BB,
        OP_START_EMIT,
        OP_T1_LOAD,
        OP_T2_LOAD,
        OP_STAY_CMP,
        OP_R1_EMIT,
        OP_DEC_LOAD,
        OP_DEC_ADD4,
        OP_DEC_SUB4_R2,
        OP_R2_EMIT
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_AB,
        ST_START_EMIT,
        ST_R1_A,
        ST_R1_B,
        ST_R1_C,
        ST_R1_D,
        ST_R1_E,
        ST_I2,
        ST_I3,
        ST_I4,
        ST_I5,
        ST_I6,
        ST_R2_A,
        ST_R2_B,
        ST_R2_C
    } state_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     mul_load;
        dp_op_t   op;
    } dp_cmd_t;

    typedef struct packed {
        logic active;
        logic region_two;
        logic stay;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ sv/eqr_ctrl.sv @@
// ----------------------------------------------------------------------------
// eqr_ctrl
// sequencer that steps the shared multiplier and the decision update
// ----------------------------------------------------------------------------
`default_nettype none

module eqr_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic             s_tuser,
    input  wire eqr_pkg::dp_stat_t stat,
    output eqr_pkg::dp_cmd_t      cmd
);
    import eqr_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd.mul_sel  = MUL_A_A;
        cmd.mul_load = 1'b0;
        cmd.op       = OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action_t'(s_tuser) == ACT_START)
                    begin
                        cmd.op     = OP_LATCH;
                        state_next = ST_SQ_A;
                    end
                    else if (stat.active)
                    begin
                        state_next = stat.region_two ? ST_R2_A : ST_R1_A;
                    end
                end
            end
            ST_SQ_A:
            begin
                cmd.mul_sel  = MUL_A_A;
                cmd.mul_load = 1'b1;
                state_next   = ST_SQ_B;
            end
            ST_SQ_B:
            begin
                cmd.mul_sel  = MUL_B_B;
                cmd.mul_load = 1'b1;
                cmd.op       = OP_LOAD_AA;
                state_next   = ST_AB;
            end
            ST_AB:
            begin
                cmd.mul_sel  = MUL_AA_B;
                cmd.mul_load = 1'b1;
                cmd.op       = OP_LOAD_BB;
                state_next   = ST_START_EMIT;
            end
            ST_START_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_START_EMIT;
                    state_next = ST_IDLE;
                end
            end
            ST_R1_A:
            begin
                cmd.mul_sel  = MUL_BB_X1;
                cmd.mul_load = 1'b1;
                state_next   = ST_R1_B;
            end
            ST_R1_B:
            begin
                cmd.mul_sel  = MUL_AA_Y2M1;
                cmd.mul_load = 1'b1;
                cmd.op       = OP_T1_LOAD;
                state_next   = ST_R1_C;
            end
            ST_R1_C:
            begin
                cmd.mul_sel  = MUL_BB_X23;
                cmd.mul_load = 1'b1;
                cmd.op       = OP_STAY_CMP;
                state_next   = ST_R1_D;
            end
            ST_R1_D:
            begin
                cmd.mul_sel  = MUL_AA_Y;
                cmd.mul_load = 1'b1;
                cmd.op       = OP_T1_LOAD;
                state_next   = ST_R1_E;
            end
            ST_R1_E:
            begin
                if (stat.stay)
                begin
                    if (stat.out_free)
                    begin
                        cmd.op     = OP_R1_EMIT;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.mul_sel  = MUL_HX_HX;
                    cmd.mul_load = 1'b1;
                    state_next   = ST_I2;
                end
            end
            ST_I2:
            begin
                cmd.mul_sel  = MUL_YM_YM;
                cmd.mul_load = 1'b1;
                cmd.op       = OP_T1_LOAD;
                state_next   = ST_I3;
            end
            ST_I3:
            begin
                cmd.mul_sel  = MUL_BB_T1;
                cmd.mul_load = 1'b1;
                cmd.op       = OP_T2_LOAD;
                state_next   = ST_I4;
            end
            ST_I4:
            begin
                cmd.mul_sel  = MUL_AA_T2;
                cmd.mul_load = 1'b1;
                cmd.op       = OP_DEC_LOAD;
                state_next   = ST_I5;
            end
            ST_I5:
            begin
                cmd.mul_sel  = MUL_AA_BB;
                cmd.mul_load = 1'b1;
                cmd.op       = OP_DEC_ADD4;
                state_next   = ST_I6;
            end
            ST_I6:
            begin
                cmd.op     = OP_DEC_SUB4_R2;
                state_next = ST_R2_A;
            end
            ST_R2_A:
            begin
                cmd.mul_sel  = MUL_AA_Y;
                cmd.mul_load = 1'b1;
                state_next   = ST_R2_B;
            end
            ST_R2_B:
            begin
                cmd.mul_sel  = MUL_BB_X1;
                cmd.mul_load = 1'b1;
                cmd.op       = OP_T1_LOAD;
                state_next   = ST_R2_C;
            end
            ST_R2_C:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_R2_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sv/eqr_datapath.sv @@
// ----------------------------------------------------------------------------
// eqr_datapath
// coordinate, square and decision registers, shared multiplier, output register
// ----------------------------------------------------------------------------
`default_nettype none

module eqr_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire eqr_pkg::dp_cmd_t              cmd,
    output eqr_pkg::dp_stat_t                  stat,
    input  wire logic [eqr_pkg::COORD_W-1:0]   axis_a,
    input  wire logic [eqr_pkg::COORD_W-1:0]   axis_b,
    input  wire logic [eqr_pkg::COLOR_W-1:0]   draw_color,
    input  wire logic                          m_tready,
    output logic                               m_tvalid,
    output logic [eqr_pkg::COORD_W-1:0]        pixel_x,
    output logic [eqr_pkg::COORD_W-1:0]        pixel_y,
    output logic [eqr_pkg::COLOR_W-1:0]        pixel_color,
    output logic                               last_pixel
);
    import eqr_pkg::*;

    // control state
    logic active_reg, active_next;
    logic r2_reg, r2_next;
    logic stay_reg, stay_next;
    logic out_valid_reg, out_valid_next;

    // payload
    logic [COORD_W-1:0] a_in_reg, a_in_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [SQ_W-1:0]    aa_reg, aa_next;
    logic [SQ_W-1:0]    bb_reg, bb_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [PROD_W-1:0]  t1_reg, t1_next;
    logic [PROD_W-1:0]  t2_reg, t2_next;
    logic [DEC_W-1:0]   dec_reg, dec_next;
    logic [COORD_W-1:0] ox_reg, ox_next;
    logic [COORD_W-1:0] oy_reg, oy_next;
    logic [COLOR_W-1:0] oc_reg, oc_next;

    logic               emit;
    logic               out_free;
    logic [COORD_W:0]   x1;
    logic [COORD_W:0]   y2m1;
    logic [COORD_W+1:0] x23;
    logic [COORD_W:0]   hx;
    logic [COORD_W-1:0] ym;
    logic [OP_W-1:0]    op_a, op_b;
    logic [DEC_W-1:0]   aa_d, bb_d, prod_d, t1_d, vert;
    logic               dec_neg;

    assign out_free = !out_valid_reg || m_tready;
    assign dec_neg  = dec_reg[DEC_W-1];

    assign x1   = {1'b0, x_reg} + (COORD_W+1)'(1);
    assign y2m1 = {y_reg, 1'b0} - (COORD_W+1)'(1);
    assign x23  = (COORD_W+2)'({x_reg, 1'b0}) + (COORD_W+2)'(3);
    assign hx   = {x_reg, 1'b1};
    assign ym   = y_reg - COORD_W'(1);

    assign aa_d   = DEC_W'(aa_reg);
    assign bb_d   = DEC_W'(bb_reg);
    assign prod_d = DEC_W'(prod_reg);
    assign t1_d   = DEC_W'(t1_reg);
    assign vert   = (aa_d << 3) + (aa_d << 2) - (t1_d << 3);

    // shared multiplier operand select
    always_comb
    begin
        op_a = OP_W'(aa_reg);
        op_b = OP_W'(y_reg);
        unique case (cmd.mul_sel)
            MUL_A_A:     begin op_a = OP_W'(a_in_reg); op_b = OP_W'(a_in_reg); end
            MUL_B_B:     begin op_a = OP_W'(y_reg);    op_b = OP_W'(y_reg);    end
            MUL_AA_B:    begin op_a = OP_W'(aa_reg);   op_b = OP_W'(y_reg);    end
            MUL_BB_X1:   begin op_a = OP_W'(bb_reg);   op_b = OP_W'(x1);       end
            MUL_AA_Y2M1: begin op_a = OP_W'(aa_reg);   op_b = OP_W'(y2m1);     end
            MUL_BB_X23:  begin op_a = OP_W'(bb_reg);   op_b = OP_W'(x23);      end
            MUL_AA_Y:    begin op_a = OP_W'(aa_reg);   op_b = OP_W'(y_reg);    end
            MUL_HX_HX:   begin op_a = OP_W'(hx);       op_b = OP_W'(hx);       end
            MUL_YM_YM:   begin op_a = OP_W'(ym);       op_b = OP_W'(ym);       end
            MUL_BB_T1:   begin op_a = OP_W'(bb_reg);   op_b = OP_W'(t1_reg);   end
            MUL_AA_T2:   begin op_a = OP_W'(aa_reg);   op_b = OP_W'(t2_reg);   end
            MUL_AA_BB:   begin op_a = OP_W'(aa_reg);   op_b = OP_W'(bb_reg);   end
            default:     begin op_a = '0;              op_b = '0;              end
        endcase
    end

    assign prod_next = cmd.mul_load ? op_a * op_b : prod_reg;

    always_comb
    begin
        active_next = active_reg;
        r2_next     = r2_reg;
        stay_next   = stay_reg;
        a_in_next   = a_in_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        aa_next     = aa_reg;
        bb_next     = bb_reg;
        t1_next     = t1_reg;
        t2_next     = t2_reg;
        dec_next    = dec_reg;
        emit        = 1'b0;
        unique case (cmd.op)
            OP_NONE:
            begin
            end
            OP_LATCH:
            begin
                a_in_next = axis_a;
                y_next    = axis_b;
                x_next    = '0;
            end
            OP_LOAD_AA:
            begin
                aa_next = SQ_W'(prod_reg);
            end
            OP_LOAD_BB:
            begin
                bb_next = SQ_W'(prod_reg);
            end
            OP_START_EMIT:
            begin
                // 4b^2 - 4a^2 b + a^2
                dec_next = (bb_d << 2) - (prod_d << 2) + aa_d;
                r2_next  = 1'b0;
                emit     = 1'b1;
            end
            OP_T1_LOAD:
            begin
                t1_next = prod_reg;
            end
            OP_T2_LOAD:
            begin
                t2_next = prod_reg;
            end
            OP_STAY_CMP:
            begin
                // 2 b^2 (x+1) < a^2 (2y-1), never once y is zero
                stay_next = (y_reg != '0) && ({t1_reg, 1'b0} < {1'b0, prod_reg});
            end
            OP_R1_EMIT:
            begin
                x_next = x_reg + COORD_W'(1);
                if (dec_neg)
                begin
                    dec_next = dec_reg + (t1_d << 2);
                end
                else
                begin
                    dec_next = dec_reg + (t1_d << 2) + (aa_d << 3) - (prod_d << 3);
                    y_next   = y_reg - COORD_W'(1);
                end
                emit = 1'b1;
            end
            OP_DEC_LOAD:
            begin
                dec_next = prod_d;
            end
            OP_DEC_ADD4:
            begin
                dec_next = dec_reg + (prod_d << 2);
            end
            OP_DEC_SUB4_R2:
            begin
                dec_next = dec_reg - (prod_d << 2);
                r2_next  = 1'b1;
            end
            OP_R2_EMIT:
            begin
                y_next = y_reg - COORD_W'(1);
                if (dec_neg)
                begin
                    dec_next = dec_reg + (prod_d << 3) + vert;
                    x_next   = x_reg + COORD_W'(1);
                end
                else
                begin
                    dec_next = dec_reg + vert;
                end
                emit = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (emit)
        begin
            active_next = (y_next != '0);
        end
    end

    // output register
    assign out_valid_next = emit ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    assign ox_next        = emit ? x_next : ox_reg;
    assign oy_next        = emit ? y_next : oy_reg;
    assign oc_next        = emit ? draw_color : oc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            r2_reg        <= 1'b0;
            stay_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            r2_reg        <= r2_next;
            stay_reg      <= stay_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_in_reg <= a_in_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        aa_reg   <= aa_next;
        bb_reg   <= bb_next;
        prod_reg <= prod_next;
        t1_reg   <= t1_next;
        t2_reg   <= t2_next;
        dec_reg  <= dec_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oc_reg   <= oc_next;
    end

    assign stat.active     = active_reg;
    assign stat.region_two = r2_reg;
    assign stat.stay       = stay_reg;
    assign stat.out_free   = out_free;

    assign m_tvalid    = out_valid_reg;
    assign pixel_x     = ox_reg;
    assign pixel_y     = oy_reg;
    assign pixel_color = oc_reg;
    assign last_pixel  = (oy_reg == '0);

endmodule

`default_nettype wire

@@ sv/ellipse_quadrant_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// ellipse_quadrant_rasterizer_core
// midpoint ellipse rasterizer, first quadrant, one pixel per start or open-arc step
// a start request passes SQ_A, SQ_B, AB and START_EMIT, a region-one step passes
//   R1_A to R1_E, a region-two step R2_A to R2_C, and the crossing step R1_A to R1_E,
//   I2 to I6 and R2_A to R2_C; a request is taken only in IDLE, once the last is done;
//   the single shared multiplier yields one registered product per cycle it is loaded
// reset: rst_n clears the sequencer, the output register and the ellipse,
//   and sets draw_color to 15
// ----------------------------------------------------------------------------
`default_nettype none

module ellipse_quadrant_rasterizer_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [eqr_pkg::S_TDATA_W-1:0]   s_tdata,  // axis_a, axis_b, zero pad
    input  wire logic                            s_tuser,  // action
    // pixel channel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [eqr_pkg::M_TDATA_W-1:0]        m_tdata,  // pixel_x, pixel_y, pixel_color
    output logic                                 m_tlast,  // last_pixel
    // color register write
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [eqr_pkg::COLOR_W-1:0]     cfg_data
);
    import eqr_pkg::*;

    // color register, written any cycle the port offers data
    logic [COLOR_W-1:0] color_reg, color_next;

    // controller <-> datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // unpacked request fields
    logic [COORD_W-1:0] axis_a;
    logic [COORD_W-1:0] axis_b;

    // unpacked pixel fields
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;

    assign axis_a = s_tdata[COORD_W-1:0];
    assign axis_b = s_tdata[2*COORD_W-1:COORD_W];

    assign cfg_ready  = 1'b1;
    assign color_next = (cfg_valid && cfg_ready) ? cfg_data : color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= COLOR_RESET;
        end
        else
        begin
            color_reg <= color_next;
        end
    end

    // sequencer: one state per multiplier issue or decision update
    eqr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // squares, decision value, coordinates and the pixel output register
    eqr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .axis_a      (axis_a),
        .axis_b      (axis_b),
        .draw_color  (color_reg),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (m_tlast)
    );

    // pack pixel fields, x in the lowest bits
    assign m_tdata = M_TDATA_W'({pixel_color, pixel_y, pixel_x});

endmodule

`default_nettype wire

@@ sv/eqr_checker.sv @@
// ----------------------------------------------------------------------------
// eqr_checker
// port-level checks of the ellipse rasterizer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module eqr_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [eqr_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);
    import eqr_pkg::*;

    // stalled pixel stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("pixel dropped while stalled");

    // stalled pixel keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("pixel payload changed while stalled");

    // a start request keeps the block busy on the next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == ACT_START) |=> !s_tready)
        else $error("request taken during start setup");

    // a new pixel only rises when the block was busy just before
    a_pixel_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("pixel produced without a request in progress");

endmodule

bind ellipse_quadrant_rasterizer_core eqr_checker u_eqr_checker (.*);

`default_nettype wire

@@ tb/eqr_pixel_checker.sv @@
// ----------------------------------------------------------------------------
// eqr_pixel_checker
// Watches the request, pixel and color channels of the ellipse rasterizer.
// It keeps its own midpoint-ellipse arc state, works out the pixel that each
// accepted request must produce, and compares every accepted pixel with the
// oldest one still owed.
// ----------------------------------------------------------------------------
module eqr_pixel_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [eqr_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [eqr_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          m_tlast,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [eqr_pkg::COLOR_W-1:0]   cfg_data,
    output int                            fail_count,
    output int                            pending,
    output logic                          arc_open
);
    timeunit 1ns;
    timeprecision 1ps;

    import eqr_pkg::*;

    localparam logic [63:0] COORD_MASK = 64'((64'd1 << COORD_W) - 64'd1);

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] color;
        logic               last;
    } pixel_t;

    pixel_t             owed_pixels[$];
    logic [COLOR_W-1:0] color_reg;
    logic [63:0]        pos_x;
    logic [63:0]        pos_y;
    logic [63:0]        decision;
    logic [63:0]        a_sq;
    logic [63:0]        b_sq;
    logic               region_two;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic owe_pixel();
        pixel_t px;
        px.x     = pos_x[COORD_W-1:0];
        px.y     = pos_y[COORD_W-1:0];
        px.color = color_reg;
        px.last  = (pos_y == 64'd0);
        if (px.last)
            arc_open = 1'b0;
        owed_pixels.push_back(px);
    endtask

    // decision is four times the midpoint value, two's complement in 64 bits
    task automatic advance_arc(input action_t act, input logic [COORD_W-1:0] a,
                               input logic [COORD_W-1:0] b);
        logic [63:0] a64;
        logic [63:0] b64;
        logic [63:0] hx;
        logic [63:0] ym;
        logic [63:0] vert;
        logic        stay;
        a64 = 64'(a);
        b64 = 64'(b);
        if (act == ACT_START)
        begin
            a_sq       = a64 * a64;
            b_sq       = b64 * b64;
            pos_x      = 64'd0;
            pos_y      = b64;
            decision   = 64'd4 * b_sq - 64'd4 * a_sq * b64 + a_sq;
            region_two = 1'b0;
            arc_open   = 1'b1;
            owe_pixel();
            return;
        end
        // steps with no arc in progress are dropped
        if (!arc_open)
            return;
        if (!region_two)
        begin
            stay = (pos_y != 64'd0) &&
                   (64'd2 * b_sq * (pos_x + 64'd1) < a_sq * (64'd2 * pos_y - 64'd1));
            if (stay)
            begin
                if (decision[63])
                    decision += 64'd4 * b_sq * (64'd2 * pos_x + 64'd3);
                else
                begin
                    decision += 64'd4 * b_sq * (64'd2 * pos_x + 64'd3)
                                + 64'd8 * a_sq - 64'd8 * a_sq * pos_y;
                    pos_y = (pos_y - 64'd1) & COORD_MASK;
                end
                pos_x = (pos_x + 64'd1) & COORD_MASK;
                owe_pixel();
                return;
            end
            // crossing: restart decision at the region-two midpoint
            region_two = 1'b1;
            hx         = 64'd2 * pos_x + 64'd1;
            ym         = pos_y - 64'd1;
            decision   = b_sq * hx * hx + 64'd4 * a_sq * ym * ym - 64'd4 * a_sq * b_sq;
        end
        vert = 64'd12 * a_sq - 64'd8 * a_sq * pos_y;
        if (decision[63])
        begin
            decision += 64'd8 * b_sq * (pos_x + 64'd1) + vert;
            pos_x = (pos_x + 64'd1) & COORD_MASK;
        end
        else
            decision += vert;
        pos_y = (pos_y - 64'd1) & COORD_MASK;
        owe_pixel();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_t want;
        if (!rst_n)
        begin
            owed_pixels.delete();
            color_reg  = COLOR_RESET;
            pos_x      = '0;
            pos_y      = '0;
            decision   = '0;
            a_sq       = '0;
            b_sq       = '0;
            region_two = 1'b0;
            arc_open   = 1'b0;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (owed_pixels.size() == 0)
                    report_mismatch($sformatf("pixel (%0d,%0d) with no request owed",
                                              m_tdata[COORD_W-1:0],
                                              m_tdata[2*COORD_W-1:COORD_W]));
                else
                begin
                    want = owed_pixels.pop_front();
                    if (m_tdata[COORD_W-1:0] !== want.x)
                        report_mismatch($sformatf("pixel_x want %0d got %0d",
                                                  want.x, m_tdata[COORD_W-1:0]));
                    if (m_tdata[2*COORD_W-1:COORD_W] !== want.y)
                        report_mismatch($sformatf("pixel_y want %0d got %0d",
                                                  want.y, m_tdata[2*COORD_W-1:COORD_W]));
                    if (m_tdata[2*COORD_W +: COLOR_W] !== want.color)
                        report_mismatch($sformatf("pixel_color want %0d got %0d",
                                                  want.color, m_tdata[2*COORD_W +: COLOR_W]));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last_pixel want %0b got %0b",
                                                  want.last, m_tlast));
                end
            end
            if (cfg_valid && cfg_ready)
                color_reg = cfg_data;
            if (s_tvalid && s_tready)
                advance_arc(action_t'(s_tuser), s_tdata[COORD_W-1:0],
                            s_tdata[2*COORD_W-1:COORD_W]);
            pending = owed_pixels.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the ellipse quadrant rasterizer core. Runs a short
// directed set of arcs, then random arcs in three flow-control phases with a
// color write between each, while eqr_pixel_checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import eqr_pkg::*;

    // cycles with no handshake on any channel before the run is called hung
    localparam int QUIET_LIMIT = 5000;
    // settle time before a color write, covers the slowest request
    localparam int SETTLE_CYCLES = 20;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // axis_a, axis_b, zero pad
    logic                 s_tuser;   // action
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // pixel_x, pixel_y, pixel_color
    logic                 m_tlast;   // last_pixel
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [COLOR_W-1:0]   cfg_data;

    int   fail_count;
    int   pending;
    logic arc_open;

    // flow-control knobs, percent of cycles spent idle
    int tx_idle_pct;
    int rx_idle_pct;
    // long receiver hold-off, counted down by the receiver process
    int rx_hold_left;
    // requests that do real work (starts, and steps on an open arc)
    int live_requests;
    int quiet_cycles;

    ellipse_quadrant_rasterizer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    eqr_pixel_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .arc_open   (arc_open)
    );

    initial
        clk = 1'b0;

    always
        #5 clk = ~clk;

    // pixel sink: random back-pressure, or a solid hold-off when asked
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_left > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one request, starting and ending on a falling edge; valid stays
    // high afterwards so back-to-back requests need no extra edge
    task automatic send_request(input action_t act, input logic [COORD_W-1:0] a,
                                input logic [COORD_W-1:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        // nothing is accepted while idling, so the arc state read here holds
        if (act == ACT_START || arc_open)
            live_requests++;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= S_TDATA_W'({b, a});
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // start an arc and step it until its last pixel or the step budget runs out;
    // step requests carry random axis bits, which the block must ignore
    task automatic run_arc(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b,
                           input int max_steps);
        int steps;
        steps = 0;
        send_request(ACT_START, a, b);
        while (arc_open && steps < max_steps)
        begin
            send_request(ACT_STEP, COORD_W'($urandom), COORD_W'($urandom));
            steps++;
        end
    endtask

    // stop offering, wait for every owed pixel, then let an ignored step drain
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_color(input logic [COLOR_W-1:0] color);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= color;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly small complete arcs, some medium ones, a few full-range arcs cut
    // short; some arcs are abandoned by a new start, some get stray steps after
    task automatic random_arcs(input int quota);
        int goal;
        int pick;
        int span;
        int budget;
        goal = live_requests + quota;
        while (live_requests < goal)
        begin
            pick = $urandom_range(99);
            span = (pick < 78) ? 16 : (pick < 92) ? 80 : 1023;
            if (span == 1023)
                budget = $urandom_range(25);
            else if ($urandom_range(99) < 15)
                budget = $urandom_range(6);
            else
                budget = 4096;
            run_arc(COORD_W'($urandom_range(span)), COORD_W'($urandom_range(span)), budget);
            if ($urandom_range(99) < 20)
                repeat ($urandom_range(2, 1))
                    send_request(ACT_STEP, COORD_W'($urandom), COORD_W'($urandom));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tuser       = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        tx_idle_pct   = 0;
        rx_idle_pct   = 25;
        rx_hold_left  = 0;
        live_requests = 0;
        quiet_cycles  = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed arcs under the reset color
        send_request(ACT_STEP, '1, '1);       // step with nothing open after reset
        run_arc(10'd0, 10'd0, 0);             // zero vertical axis ends on the start
        send_request(ACT_STEP, '0, '0);       // step after the last pixel
        run_arc(10'd0, 10'd3, 4096);          // zero horizontal axis goes straight to region two
        run_arc(10'd6, 10'd0, 0);
        run_arc(10'd1023, 10'd1023, 4);       // largest axes, then dropped by a new start
        run_arc(10'd3, 10'd2, 4096);          // full small arc through the region crossing
        send_request(ACT_STEP, '1, '0);
        run_arc(10'd1, 10'd1023, 2);          // tall and thin
        run_arc(10'd1023, 10'd1, 2);          // wide and flat
        drain();

        // sender mostly busy, receiver mostly stalled
        write_color('0);
        tx_idle_pct = 9;
        rx_idle_pct = 88;
        random_arcs(410);

        // sender mostly idle, receiver mostly ready
        write_color(COLOR_W'($urandom_range(14, 1)));
        tx_idle_pct = 88;
        rx_idle_pct = 9;
        random_arcs(410);

        // no idling, opened by a long receiver hold-off that backs up the block
        write_color('1);
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        rx_hold_left = 400;
        random_arcs(410);

        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
